FILE: hw/rtl/dmsl_pkg.sv
// Package for the drive mixer with slew limiter.
// Holds the payload, configuration and job types, register indexes and
// reset values. No dependencies.
`timescale 1ns / 1ps

package dmsl_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int TARGET_W    = 18;
   localparam int TURN_W      = 22;
   localparam int FORWARD_W   = 20;

   localparam int JOB_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_SCALE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_SCALE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_SLEW_STEP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REV_SLEW_STEP = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_LIMIT = 3'd5;

   typedef enum logic [1:0] {
      MODE_TANK   = 2'd0,
      MODE_ARCADE = 2'd1,
      MODE_SPLIT  = 2'd2
   } dmsl_mode_type;

   localparam logic [1:0]  RESET_DRIVE_MODE    = MODE_SPLIT;
   localparam logic [11:0] RESET_DRIVE_SCALE   = 12'd256;
   localparam logic [11:0] RESET_TURN_SCALE    = 12'd256;
   localparam logic [12:0] RESET_FWD_SLEW_STEP = 13'd256;
   localparam logic [12:0] RESET_REV_SLEW_STEP = 13'd614;
   localparam logic [11:0] RESET_VOLTAGE_LIMIT = 12'd3072;

   typedef struct packed {
      logic signed [7:0] left_x;
      logic signed [7:0] left_y;
      logic signed [7:0] right_x;
      logic signed [7:0] right_y;
   } dmsl_req_type;

   typedef struct packed {
      logic signed [15:0] left_command;
      logic signed [15:0] right_command;
      logic               command_is_voltage;
   } dmsl_rsp_type;

   typedef struct packed {
      logic [1:0]  drive_mode;
      logic [11:0] drive_scale;
      logic [11:0] turn_scale;
      logic [12:0] fwd_slew_step;
      logic [12:0] rev_slew_step;
      logic [11:0] voltage_limit;
   } dmsl_cfg_type;

   typedef struct packed {
      logic                       split;
      logic signed [15:0]         cmd_left;
      logic signed [15:0]         cmd_right;
      logic signed [TARGET_W-1:0] target;
      logic signed [TURN_W-1:0]   turn;
   } dmsl_job_type;

endpackage

FILE: hw/rtl/dmsl_fifo.sv
// Small register queue used between the front and back parts and at the output.
// Stands alone; the item type is given by the instantiating module.
`timescale 1ns / 1ps

module dmsl_fifo #(
   parameter int  DEPTH     = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/dmsl_front.sv
// Front part: accepts stick transactions, forms the products and classifies by mode.
// Depends on dmsl_pkg.
`timescale 1ns / 1ps

module dmsl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  dmsl_pkg::dmsl_cfg_type cfg,
   input  logic                  req_push,
   output logic                  req_full,
   input  dmsl_pkg::dmsl_req_type req_data,
   output logic                  job_push,
   output dmsl_pkg::dmsl_job_type job_data,
   input  logic                  job_full
);

   function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
      logic signed [15:0] r;
      if (v > 27'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -27'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic               accept;
   logic signed [12:0] ds_s, ts_s;

   logic               s1_valid_ff, s1_valid_in;
   logic signed [7:0]  s1_ly_ff, s1_ry_ff;
   logic signed [20:0] s1_fwd_ff, s1_fwd_in;
   logic signed [20:0] s1_rt_ff, s1_rt_in;
   logic signed [20:0] s1_lt_ff, s1_lt_in;

   logic               s2_valid_ff, s2_valid_in;
   logic signed [7:0]  s2_ly_ff, s2_ry_ff;
   logic signed [20:0] s2_fwd_ff;
   logic signed [33:0] s2_turn_ff, s2_turn_in;
   logic signed [34:0] s2_mixl_ff, s2_mixl_in;
   logic signed [34:0] s2_mixr_ff, s2_mixr_in;

   logic signed [21:0] fwd_q, lt_q, sum_l, sum_r;

   assign accept   = req_push & ~req_full;
   assign req_full = s1_valid_ff | s2_valid_ff;
   assign ds_s     = $signed({1'b0, cfg.drive_scale});
   assign ts_s     = $signed({1'b0, cfg.turn_scale});

   always_comb begin
      s1_fwd_in = req_data.left_y * ds_s;
      s1_rt_in  = req_data.right_x * ts_s;
      s1_lt_in  = req_data.left_x * ts_s;
   end

   always_comb begin
      fwd_q      = {{6{s1_ly_ff[7]}}, s1_ly_ff, 8'h00};
      lt_q       = {s1_lt_ff[20], s1_lt_ff};
      sum_l      = fwd_q + lt_q;
      sum_r      = fwd_q - lt_q;
      s2_turn_in = s1_rt_ff * ds_s;
      s2_mixl_in = sum_l * ds_s;
      s2_mixr_in = sum_r * ds_s;
   end

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff | (s2_valid_ff & job_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ly_ff  <= req_data.left_y;
         s1_ry_ff  <= req_data.right_y;
         s1_fwd_ff <= s1_fwd_in;
         s1_rt_ff  <= s1_rt_in;
         s1_lt_ff  <= s1_lt_in;
      end
      if (s1_valid_ff) begin
         s2_ly_ff   <= s1_ly_ff;
         s2_ry_ff   <= s1_ry_ff;
         s2_fwd_ff  <= s1_fwd_ff;
         s2_turn_ff <= s2_turn_in;
         s2_mixl_ff <= s2_mixl_in;
         s2_mixr_ff <= s2_mixr_in;
      end
   end

   assign job_push = s2_valid_ff;

   always_comb begin
      job_data.split     = 1'b0;
      job_data.cmd_left  = '0;
      job_data.cmd_right = '0;
      job_data.target    = s2_fwd_ff[20:3];
      job_data.turn      = s2_turn_ff[32:11];
      case (cfg.drive_mode)
         dmsl_pkg::MODE_TANK: begin
            job_data.cmd_left  = {s2_ly_ff, 8'h00};
            job_data.cmd_right = {s2_ry_ff, 8'h00};
         end
         dmsl_pkg::MODE_ARCADE: begin
            job_data.cmd_left  = sat16(s2_mixl_ff[34:8]);
            job_data.cmd_right = sat16(s2_mixr_ff[34:8]);
         end
         dmsl_pkg::MODE_SPLIT: begin
            job_data.split = 1'b1;
         end
         default: begin
            job_data.split = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/dmsl_back.sv
// Back part: in split mode applies the forward slew limiter, adds the turn and clamps;
// other modes pass the front part's commands through. Depends on dmsl_pkg.
`timescale 1ns / 1ps

module dmsl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dmsl_pkg::dmsl_cfg_type cfg,
   input  logic                  job_empty,
   input  dmsl_pkg::dmsl_job_type job_data,
   output logic                  job_pop,
   output logic                  rsp_push,
   output dmsl_pkg::dmsl_rsp_type rsp_data,
   input  logic                  rsp_full
);

   localparam int FW = dmsl_pkg::FORWARD_W;
   localparam int SW = dmsl_pkg::FORWARD_W + 3;

   function automatic logic signed [15:0] clamp(input logic signed [SW-1:0] v,
                                                input logic signed [SW-1:0] lim);
      logic signed [SW-1:0] r;
      r = v;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r[15:0];
   endfunction

   logic                   b_valid_ff, b_valid_in;
   dmsl_pkg::dmsl_job_type b_job_ff;
   logic signed [FW-1:0]   fwd_ff, fwd_in;

   logic signed [FW-1:0]   cur, tgt, slewed;
   logic signed [FW:0]     delta, step, ext_cur, moved_up, moved_down;
   logic                   cur_pos, cur_neg, limited;
   logic signed [SW-1:0]   sum_l, sum_r, lim_s;

   assign rsp_push = b_valid_ff;
   assign job_pop  = ~job_empty & (~b_valid_ff | ~rsp_full);

   always_comb begin
      cur        = fwd_ff;
      tgt        = FW'(job_data.target);
      ext_cur    = {cur[FW-1], cur};
      delta      = {tgt[FW-1], tgt} - ext_cur;
      cur_pos    = ~cur[FW-1] && (cur != '0);
      cur_neg    = cur[FW-1];
      limited    = (tgt != '0) && ((cur_pos && (tgt < cur)) || (cur_neg && (tgt > cur)));
      step       = cur_pos ? $signed((FW + 1)'(cfg.fwd_slew_step))
                           : $signed((FW + 1)'(cfg.rev_slew_step));
      moved_up   = ext_cur + step;
      moved_down = ext_cur - step;
      if (limited && (delta > step)) begin
         slewed = moved_up[FW-1:0];
      end else if (limited && (delta < -step)) begin
         slewed = moved_down[FW-1:0];
      end else begin
         slewed = tgt;
      end
      fwd_in = (job_pop && job_data.split) ? slewed : fwd_ff;
   end

   assign b_valid_in = job_pop | (b_valid_ff & rsp_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_ff     <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         fwd_ff     <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         b_job_ff <= job_data;
      end
   end

   always_comb begin
      sum_l = SW'(fwd_ff) + SW'(b_job_ff.turn);
      sum_r = SW'(fwd_ff) - SW'(b_job_ff.turn);
      lim_s = $signed(SW'(cfg.voltage_limit));
      if (b_job_ff.split) begin
         rsp_data.left_command       = clamp(sum_l, lim_s);
         rsp_data.right_command      = clamp(sum_r, lim_s);
         rsp_data.command_is_voltage = 1'b1;
      end else begin
         rsp_data.left_command       = b_job_ff.cmd_left;
         rsp_data.right_command      = b_job_ff.cmd_right;
         rsp_data.command_is_voltage = 1'b0;
      end
   end

endmodule

FILE: hw/rtl/drive_mix_slew_limiter.sv
// Drive mixer with slew limiter: top level with the configuration registers.
// Path: an accepted transaction is registered in both front stages, the job queue,
// the back part's register and the response queue. The front part's two multiplier
// stages take one transaction at a time and accept a new one only once both are empty.
// Reset: configuration returns to its defaults, the applied forward value to zero,
// and both queues are emptied. Depends on dmsl_pkg, dmsl_front, dmsl_fifo, dmsl_back.
`timescale 1ns / 1ps

module drive_mix_slew_limiter #(
   parameter int JOB_QUEUE_DEPTH = dmsl_pkg::JOB_QUEUE_DEPTH,
   parameter int RSP_QUEUE_DEPTH = dmsl_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  dmsl_pkg::dmsl_req_type                req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output dmsl_pkg::dmsl_rsp_type                rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmsl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dmsl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   dmsl_pkg::dmsl_cfg_type cfg_ff, cfg_in;
   logic                   job_push, job_full, job_pop, job_empty;
   dmsl_pkg::dmsl_job_type job_in_data, job_out_data;
   logic                   out_push, out_full;
   dmsl_pkg::dmsl_rsp_type out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dmsl_pkg::CSR_DRIVE_MODE:    cfg_in.drive_mode    = csr_wdata[1:0];
            dmsl_pkg::CSR_DRIVE_SCALE:   cfg_in.drive_scale   = csr_wdata[11:0];
            dmsl_pkg::CSR_TURN_SCALE:    cfg_in.turn_scale    = csr_wdata[11:0];
            dmsl_pkg::CSR_FWD_SLEW_STEP: cfg_in.fwd_slew_step = csr_wdata[12:0];
            dmsl_pkg::CSR_REV_SLEW_STEP: cfg_in.rev_slew_step = csr_wdata[12:0];
            dmsl_pkg::CSR_VOLTAGE_LIMIT: cfg_in.voltage_limit = csr_wdata[11:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_mode    <= dmsl_pkg::RESET_DRIVE_MODE;
         cfg_ff.drive_scale   <= dmsl_pkg::RESET_DRIVE_SCALE;
         cfg_ff.turn_scale    <= dmsl_pkg::RESET_TURN_SCALE;
         cfg_ff.fwd_slew_step <= dmsl_pkg::RESET_FWD_SLEW_STEP;
         cfg_ff.rev_slew_step <= dmsl_pkg::RESET_REV_SLEW_STEP;
         cfg_ff.voltage_limit <= dmsl_pkg::RESET_VOLTAGE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dmsl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_push (job_push),
      .job_data (job_in_data),
      .job_full (job_full)
   );

   dmsl_fifo #(
      .DEPTH     (JOB_QUEUE_DEPTH),
      .item_type (dmsl_pkg::dmsl_job_type)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   dmsl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_push  (out_push),
      .rsp_data  (out_data),
      .rsp_full  (out_full)
   );

   dmsl_fifo #(
      .DEPTH     (RSP_QUEUE_DEPTH),
      .item_type (dmsl_pkg::dmsl_rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
